>>> rtl/core/msdp_pkg.sv
// Package for the maintenance-aware subset DP scheduler.
// Holds sizes, payload structs, job record type and the job timing function.
// No dependencies.
package msdp_pkg;

    localparam int MAX_JOBS   = 6;
    localparam int TIME_SLOTS = 256;
    localparam int JW         = $clog2(MAX_JOBS + 1);
    localparam int JIW        = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int TW         = $clog2(TIME_SLOTS);
    localparam int ENTRIES    = (1 << MAX_JOBS) * TIME_SLOTS;
    localparam int AW         = MAX_JOBS + TW;
    localparam int VW         = TW + 1;
    localparam logic [VW-1:0] NO_VAL = {VW{1'b1}};

    localparam logic [1:0] ADDR_MAINT_START  = 2'd0;
    localparam logic [1:0] ADDR_MAINT_LENGTH = 2'd1;

    typedef struct packed {
        logic [5:0] base_time;
        logic [5:0] late_cut;
        logic [5:0] after_maint_cut;
        logic [7:0] due_time;
        logic       last_job;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] best_makespan;
        logic       found;
        logic       time_overflow;
        logic       too_many_jobs;
    } t_out_beat;

    typedef struct packed {
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] c;
        logic [7:0] d;
    } t_job;

    // Finish time of a job started no earlier than t; bit 10 set means beyond table.
    function automatic logic [10:0] job_finish(
        input t_job        j,
        input logic [TW-1:0] t,
        input logic [7:0]  ms,
        input logic [7:0]  ml
    );
        logic [9:0] st;
        logic [9:0] we;
        logic [5:0] cut;
        logic [5:0] run;
        logic [10:0] fin;
        we = {2'b0, ms} + {2'b0, ml};
        st = 10'(t);
        if (st < {2'b0, ms} && st + {4'b0, j.a} > {2'b0, ms})
            st = we;
        if (st >= {2'b0, ms} && st < we)
            st = we;
        if (st < {2'b0, j.d})
            cut = 6'd0;
        else if (st < {2'b0, ms})
            cut = j.b;
        else
            cut = j.c;
        run = (j.a > cut) ? j.a - cut : 6'd0;
        fin = {1'b0, st} + {5'b0, run};
        if (fin >= 11'(TIME_SLOTS))
            fin[10] = 1'b1;
        return fin;
    endfunction

endpackage

>>> rtl/core/msdp_table.sv
// DP table memory: one write port and one registered read port.
// Depends on msdp_pkg.
module msdp_table
    import msdp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [VW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [VW-1:0] o_rdata
);
    logic [VW-1:0] r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/maintenance_aware_subset_dp_scheduler.sv
// Maintenance-aware subset DP scheduler (top level).
// Job store, APB registers, sweep sequencer; uses msdp_pkg and msdp_table.
//
// Usage: jobs arrive one beat each on i_in_*; a beat with last_job set
// closes the batch, starts the sweep, and yields one result beat on o_out_*.
// Other beats give no result. Extra jobs beyond MAX_JOBS are dropped and
// reported by too_many_jobs.
// The sweep runs over the DP table memory (one read, one write port):
// first a clearing pass over all 2^MAX_JOBS*TIME_SLOTS entries (16384), then
// each of the 2^n*TIME_SLOTS (subset, time) entries of n stored jobs is
// read; an unreachable entry is skipped, else each job already in the
// subset is passed over and each other job takes a table read then a
// write; then the full-set row is scanned and the result is loaded.
// Input is not accepted during the sweep.
// The result sits in an output register until taken; the next batch may
// start loading while it waits, but a new sweep waits for it to drain.
// Reset (synchronous, active low) clears counts, registers and control;
// the table is cleared at the start of each sweep.
module maintenance_aware_subset_dp_scheduler
    import msdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_JRD   = 3'd3;
    localparam logic [2:0] S_JWR   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    r_state;
    logic [7:0]    r_ms, r_ml;
    t_job          r_jobs [MAX_JOBS];
    logic [JW-1:0] r_cnt;
    logic          r_ovf, r_drop;
    logic [AW-1:0] r_addr;
    logic [MAX_JOBS-1:0] r_mask;
    logic [TW-1:0] r_t;
    logic [JIW-1:0] r_j;
    logic [VW-1:0] r_cur, r_best;
    logic [TW:0]   r_fin;
    logic [VW-1:0] r_val;
    logic          r_scan_live;
    logic          r_out_valid;
    t_out_beat     r_out;

    logic          tbl_we;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    logic [VW-1:0] tbl_wdata, tbl_rdata;
    logic [MAX_JOBS-1:0] full;
    logic [MAX_JOBS-1:0] nm;
    logic [10:0]   fin;
    logic          accept, jlast, tlast;

    msdp_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2:2])
            1'b0:    prdata = {24'd0, r_ms};
            default: prdata = {24'd0, r_ml};
        endcase
    end

    assign full   = MAX_JOBS'((1 << r_cnt) - 1);
    assign nm     = r_mask | MAX_JOBS'(1 << r_j);
    assign fin    = job_finish(r_jobs[r_j], r_t, r_ms, r_ml);
    assign jlast  = (JW'(r_j) == r_cnt - JW'(1)) || (r_cnt == '0);
    assign tlast  = (r_t == TW'(TIME_SLOTS - 1));
    assign o_in_ready  = (r_state == S_LOAD) && !(i_in_data.last_job && r_out_valid);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Table port control
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_addr;
        tbl_wdata = NO_VAL;
        tbl_raddr = {r_mask, r_t};
        case (r_state)
            S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_wdata = (r_addr == '0) ? '0 : NO_VAL;
            end
            S_JRD: tbl_raddr = {nm, fin[TW-1:0]};
            S_JWR: begin
                tbl_waddr = {nm, r_fin[TW-1:0]};
                tbl_wdata = r_val;
                tbl_we    = !r_fin[TW] && (r_val < tbl_rdata);
            end
            S_SCAN: tbl_raddr = {full, r_t};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ms        <= '0;
            r_ml        <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2:2] == ADDR_MAINT_START[0]) r_ms <= pwdata[7:0];
                else                                   r_ml <= pwdata[7:0];
            end
            if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_LOAD: if (accept) begin
                    if (r_cnt < JW'(MAX_JOBS)) begin
                        r_jobs[r_cnt[JIW-1:0]] <= '{i_in_data.base_time,
                            i_in_data.late_cut, i_in_data.after_maint_cut,
                            i_in_data.due_time};
                        r_cnt <= r_cnt + JW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if (i_in_data.last_job) begin
                        r_state <= S_CLEAR;
                        r_addr  <= '0;
                        r_drop  <= 1'b0;
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(ENTRIES - 1)) begin
                        r_mask  <= '0;
                        r_t     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // read presented; data valid next cycle
                    r_j     <= '0;
                    r_state <= S_JRD;
                end
                S_JRD: begin
                    if (r_j == JIW'(0) && r_cnt != '0) r_cur <= tbl_rdata;
                    // skip on empty entry, job already used, or empty store
                    if (r_cnt == '0 || (r_j == JIW'(0) ? tbl_rdata : r_cur) == NO_VAL
                        || r_mask[r_j]) begin
                        if (r_cnt != '0 && jlast == 1'b0
                            && (r_j == JIW'(0) ? tbl_rdata : r_cur) != NO_VAL)
                            r_j <= r_j + JIW'(1);
                        else begin
                            if (tlast) begin
                                r_t <= '0;
                                if (r_mask == full) begin
                                    r_best  <= NO_VAL;
                                    r_scan_live <= 1'b0;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_mask  <= r_mask + MAX_JOBS'(1);
                                    r_state <= S_RD;
                                end
                            end else begin
                                r_t     <= r_t + TW'(1);
                                r_state <= S_RD;
                            end
                        end
                    end else begin
                        r_fin <= fin[10] ? {1'b1, TW'(0)} : {1'b0, fin[TW-1:0]};
                        if (fin[10]) r_drop <= 1'b1;
                        r_val <= ((r_j == JIW'(0) ? tbl_rdata : r_cur) > VW'(fin[TW-1:0]))
                            ? (r_j == JIW'(0) ? tbl_rdata : r_cur) : VW'(fin[TW-1:0]);
                        r_state <= S_JWR;
                    end
                end
                S_JWR: begin
                    if (!jlast) begin
                        r_j     <= r_j + JIW'(1);
                        r_state <= S_JRD;
                    end else if (tlast) begin
                        r_t <= '0;
                        if (r_mask == full) begin
                            r_best  <= NO_VAL;
                            r_scan_live <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_mask  <= r_mask + MAX_JOBS'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_t     <= r_t + TW'(1);
                        r_state <= S_RD;
                    end
                end
                S_SCAN: begin
                    r_scan_live <= 1'b1;
                    if (r_scan_live && tbl_rdata < r_best) r_best <= tbl_rdata;
                    if (r_scan_live && r_t == '0) r_state <= S_DONE;
                    else r_t <= r_t + TW'(1);
                end
                S_DONE: begin
                    r_out.found         <= (r_best != NO_VAL);
                    r_out.best_makespan <= (r_best != NO_VAL) ? 8'(r_best) : 8'd0;
                    r_out.time_overflow <= r_drop;
                    r_out.too_many_jobs <= r_ovf;
                    r_out_valid <= 1'b1;
                    r_cnt   <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // A table write never lands outside the sweep.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> (r_state == S_CLEAR || r_state == S_JWR))
        else $error("table write outside sweep");
    // Job count never exceeds the store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= JW'(MAX_JOBS)) else $error("job count overflow");
    // Result is raised only from the final state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result without sweep");
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for maintenance_aware_subset_dp_scheduler.
// Loads job batches over the valid/ready input, programs the window over APB,
// and checks each makespan result against an in-bench DP. Depends on msdp_pkg.
`timescale 1ns / 100ps

module testbench;
    import msdp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_beat    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    maintenance_aware_subset_dp_scheduler i_dut (.*);

    always #5 i_clk = ~i_clk;

    t_in_beat  job_feed_q[$];
    t_out_beat makespan_q[$];
    t_job      batch_jobs[MAX_JOBS];
    int        batch_count = 0;
    bit        batch_refused = 0;
    int        win_start = 0;
    int        win_len = 0;
    logic [8:0] span_tbl[1 << MAX_JOBS][TIME_SLOTS];
    int        jobs_taken = 0;
    int        results_seen = 0;
    int        errors = 0;
    int        quiet_cycles = 0;
    bit        hold_done = 0;
    int        hold_left = 0;

    // Best makespan over the loaded batch for the current window.
    function automatic t_out_beat schedule_batch();
        t_out_beat r;
        int full, win_end, st, cut, run, fin, val, nm, cur, best;
        full = (1 << batch_count) - 1;
        win_end = win_start + win_len;
        best = 511;
        r = '0;
        for (int m = 0; m < (1 << MAX_JOBS); m++)
            for (int t = 0; t < TIME_SLOTS; t++) span_tbl[m][t] = 9'h1ff;
        span_tbl[0][0] = 0;
        for (int m = 0; m <= full; m++) begin
            for (int t = 0; t < TIME_SLOTS; t++) begin
                cur = span_tbl[m][t];
                if (cur == 511) continue;
                for (int j = 0; j < batch_count; j++) begin
                    if (m & (1 << j)) continue;
                    nm = m | (1 << j);
                    st = t;
                    if (st < win_start && st + batch_jobs[j].a > win_start) st = win_end;
                    if (st >= win_start && st < win_end) st = win_end;
                    if (st < batch_jobs[j].d) cut = 0;
                    else if (st < win_start) cut = batch_jobs[j].b;
                    else cut = batch_jobs[j].c;
                    run = (batch_jobs[j].a > cut) ? batch_jobs[j].a - cut : 0;
                    fin = st + run;
                    if (fin >= TIME_SLOTS) begin
                        r.time_overflow = 1'b1;
                        continue;
                    end
                    val = (cur > fin) ? cur : fin;
                    if (val < span_tbl[nm][fin]) span_tbl[nm][fin] = val;
                end
            end
        end
        for (int t = 0; t < TIME_SLOTS; t++)
            if (span_tbl[full][t] < best) best = span_tbl[full][t];
        r.found = (best != 511);
        r.best_makespan = r.found ? best[7:0] : 8'd0;
        r.too_many_jobs = batch_refused;
        return r;
    endfunction

    task automatic take_job(input t_in_beat bt);
        if (batch_count < MAX_JOBS) begin
            batch_jobs[batch_count] = '{a: bt.base_time, b: bt.late_cut,
                                        c: bt.after_maint_cut, d: bt.due_time};
            batch_count++;
        end else begin
            batch_refused = 1;
        end
        if (bt.last_job) begin
            makespan_q.push_back(schedule_batch());
            batch_count = 0;
            batch_refused = 0;
        end
    endtask

    // Input driver: hold a beat until taken, idle at random outside the calm stretch.
    always @(posedge i_clk) begin
        bit fire;
        if (i_rst_n) begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                take_job(i_in_data);
                jobs_taken++;
            end
            if (!i_in_valid || fire) begin
                if (job_feed_q.size() != 0 &&
                    ((jobs_taken >= 40 && jobs_taken < 60) || $urandom_range(99) >= 29)) begin
                    i_in_data <= job_feed_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (makespan_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_data);
                    errors++;
                end else begin
                    want = makespan_q.pop_front();
                    if (want.best_makespan !== o_out_data.best_makespan)
                        $display("%0t: best_makespan expected %0d actual %0d", $time,
                                 want.best_makespan, o_out_data.best_makespan);
                    if (want.found !== o_out_data.found)
                        $display("%0t: found expected %0b actual %0b", $time,
                                 want.found, o_out_data.found);
                    if (want.time_overflow !== o_out_data.time_overflow)
                        $display("%0t: time_overflow expected %0b actual %0b", $time,
                                 want.time_overflow, o_out_data.time_overflow);
                    if (want.too_many_jobs !== o_out_data.too_many_jobs)
                        $display("%0t: too_many_jobs expected %0b actual %0b", $time,
                                 want.too_many_jobs, o_out_data.too_many_jobs);
                    if (want !== o_out_data) errors++;
                end
            end
            // Hold off once on a waiting result so the next batch backs up.
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 10 && o_out_valid
                         && !(o_out_valid && i_out_ready)) begin
                hold_done <= 1;
                hold_left <= 600;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (jobs_taken >= 40 && jobs_taken < 60) ||
                               ($urandom_range(99) >= 29);
            end
        end
    end

    // Watchdog on cycles with no beat moving.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 1000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx[0], 2'b00};
        pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == ADDR_MAINT_START) win_start = val;
        else win_len = val;
    endtask

    task automatic add_job(input int a, input int b, input int c, input int d,
                           input bit last);
        t_in_beat bt;
        bt.base_time = 6'(a);
        bt.late_cut = 6'(b);
        bt.after_maint_cut = 6'(c);
        bt.due_time = 8'(d);
        bt.last_job = last;
        job_feed_q.push_back(bt);
    endtask

    // Mostly short batches keep the sweeps cheap; a few run full or overfull.
    task automatic add_random_batch();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
            add_job($urandom_range(63), $urandom_range(63), $urandom_range(63),
                    $urandom_range(255), k == n - 1);
    endtask

    task automatic drain();
        while (job_feed_q.size() != 0 || i_in_valid || makespan_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Reset window: single job on time, and a late job with a cut past its base.
        add_job(63, 0, 0, 255, 1);
        add_job(10, 40, 50, 0, 1);
        drain();
        write_reg(ADDR_MAINT_START, 8'd20);
        write_reg(ADDR_MAINT_LENGTH, 8'd30);
        // Straddling and late-after-window jobs.
        add_job(30, 5, 7, 0, 0);
        add_job(15, 63, 2, 40, 1);
        // Overfull store.
        for (int k = 0; k < 7; k++) add_job(k + 1, 1, 2, 100, k == 6);
        drain();
        write_reg(ADDR_MAINT_START, 8'd255);
        write_reg(ADDR_MAINT_LENGTH, 8'd255);
        // All finishes beyond the table: no schedule.
        add_job(63, 0, 0, 255, 0);
        add_job(63, 0, 0, 255, 0);
        add_job(63, 0, 0, 255, 0);
        add_job(63, 0, 0, 255, 0);
        add_job(63, 0, 0, 255, 1);
        add_job(1, 0, 0, 0, 1);
        drain();
        write_reg(ADDR_MAINT_START, 8'd0);
        write_reg(ADDR_MAINT_LENGTH, 8'd255);
        add_job(5, 1, 63, 0, 1);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(ADDR_MAINT_START, (ph == 0) ? 8'd255 : 8'($urandom_range(160)));
            write_reg(ADDR_MAINT_LENGTH, (ph == 0) ? 8'd0 : 8'($urandom_range(255)));
            for (int b = 0; b < 8; b++) add_random_batch();
            drain();
        end
        repeat (50) @(posedge i_clk);
        $display("covered %0d job beats and %0d makespan results", jobs_taken, results_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
